### rtl/mbrx_pkg.sv
// Shared constants, types and CRC helper for the Modbus RTU frame receiver.
package mbrx_pkg;

  // Frame limits and protocol constants
  localparam int unsigned FRAME_MAX   = 256;
  localparam int unsigned PAYLOAD_MAX = 32;
  localparam int unsigned MIN_FRAME   = 5;
  localparam int unsigned IDX_W       = $clog2(PAYLOAD_MAX);

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [9:0]  GAP_RESET         = 10'd4;

  // Result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_CRC  = 2'd1;
  localparam logic [1:0] ST_FUNC = 2'd2;
  localparam logic [1:0] ST_LEN  = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;    // capture the input transfer
    logic start_run;  // latch the frame verdict, index to zero
    logic clr_frame;  // empty the frame
    logic rd_en;      // read a payload entry
    logic advance;    // step to the next payload entry
    logic take;       // fold the held byte into the frame
  } mbrx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic gap_close;  // silence exceeded: the open frame closes
    logic report;     // closed frame is long enough to report
    logic run_last;   // current result ends the run
  } mbrx_sts_t;

  // One byte of CRC-16/Modbus, bitwise reflected
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/mbrx_ctrl.sv
// Controller state machine sequencing byte intake and the result run.
module mbrx_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  mbrx_pkg::mbrx_sts_t sts,
  output mbrx_pkg::mbrx_cmd_t cmd
);
  import mbrx_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_READ  = 5'b00100,
    S_OUT   = 5'b01000,
    S_TAKE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.gap_close && sts.report) begin
          cmd.start_run = 1'b1;
          state_nxt     = S_READ;
        end else begin
          // short frame is dropped without a result
          cmd.clr_frame = sts.gap_close;
          state_nxt     = S_TAKE;
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.run_last) begin
            cmd.clr_frame = 1'b1;
            state_nxt     = S_TAKE;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.advance = 1'b1;
          end
        end
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/mbrx_dp.sv
// Datapath: frame state, running CRC, payload memory and result fields.
module mbrx_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [9:0]          cfg_gap_ms,
  input  logic [7:0]          in_rx_byte,
  input  logic [31:0]         in_time_ms,
  input  mbrx_pkg::mbrx_cmd_t cmd,
  output mbrx_pkg::mbrx_sts_t sts,
  output logic [1:0]          out_status,
  output logic [7:0]          out_slave_address,
  output logic [7:0]          out_function_code,
  output logic [7:0]          out_byte_count,
  output logic [4:0]          out_data_index,
  output logic [7:0]          out_data_byte,
  output logic [15:0]         out_crc_computed,
  output logic [15:0]         out_crc_received,
  output logic                out_last
);
  import mbrx_pkg::*;

  logic [9:0]       gap_r;
  logic [7:0]       byte_r;
  logic [31:0]      time_r;
  logic [8:0]       bytes_r;
  logic [31:0]      last_time_r;
  logic [15:0]      crc_r;
  logic [15:0]      frozen_r;
  logic [15:0]      frame_crc_r;
  logic [7:0]       addr_r;
  logic [7:0]       func_r;
  logic [7:0]       len_r;
  logic [1:0]       status_r;
  logic [IDX_W-1:0] idx_r;
  logic [7:0]       rd_data_r;
  logic [7:0]       mem [PAYLOAD_MAX];

  logic [31:0]      elapsed;
  logic [8:0]       need_bytes;
  logic [1:0]       verdict;
  logic [9:0]       pos;
  logic [9:0]       crc_end;
  logic [8:0]       wr_off;
  logic [15:0]      crc_base;
  logic [15:0]      crc_upd;
  logic             wr_en;
  logic [IDX_W-1:0] rd_addr;
  logic             has_crc;

  // Close decision and frame verdict
  assign elapsed    = time_r - last_time_r;
  assign need_bytes = 9'(MIN_FRAME) + {1'b0, len_r};
  always_comb begin
    if (func_r != FUNC_READ_HOLDING) begin
      verdict = ST_FUNC;
    end else if (len_r > 8'(PAYLOAD_MAX) || bytes_r < need_bytes) begin
      verdict = ST_LEN;
    end else if (frozen_r == frame_crc_r) begin
      verdict = ST_OK;
    end else begin
      verdict = ST_CRC;
    end
  end
  assign sts.gap_close = (bytes_r != 9'd0) && (elapsed > {22'd0, gap_r});
  assign sts.report    = bytes_r >= 9'(MIN_FRAME);

  // Byte intake helpers
  assign pos      = {1'b0, bytes_r};
  assign crc_end  = 10'd3 + {2'b00, len_r};
  assign wr_off   = bytes_r - 9'd3;
  assign crc_base = (bytes_r == 9'd0) ? CRC_INIT : crc_r;
  assign crc_upd  = crc_byte(crc_base, byte_r);
  assign wr_en    = cmd.take && (bytes_r < 9'(FRAME_MAX)) && (pos >= 10'd3) &&
                    (pos < crc_end) && (bytes_r < 9'(PAYLOAD_MAX + 3));

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= GAP_RESET;
    end else if (cfg_valid) begin
      gap_r <= cfg_gap_ms;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      byte_r <= in_rx_byte;
      time_r <= in_time_ms;
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r     <= '0;
      last_time_r <= '0;
      crc_r       <= CRC_INIT;
      frozen_r    <= '0;
      frame_crc_r <= '0;
      addr_r      <= '0;
      func_r      <= '0;
      len_r       <= '0;
    end else if (cmd.clr_frame) begin
      bytes_r <= '0;
    end else if (cmd.take) begin
      if (bytes_r < 9'(FRAME_MAX)) begin
        if (bytes_r == 9'd0) addr_r <= byte_r;
        if (bytes_r == 9'd1) func_r <= byte_r;
        if (bytes_r == 9'd2) len_r  <= byte_r;
        if (pos < 10'd3 || pos < crc_end) begin
          crc_r <= crc_upd;
        end else if (pos == crc_end) begin
          frozen_r    <= crc_r;
          frame_crc_r <= {8'h00, byte_r};
        end else if (pos == crc_end + 10'd1) begin
          frame_crc_r[15:8] <= byte_r;
        end
        bytes_r     <= bytes_r + 9'd1;
        last_time_r <= time_r;
      end else begin
        // overflow: frame and byte are discarded
        bytes_r <= '0;
      end
    end
  end

  // Run control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_OK;
      idx_r    <= '0;
    end else if (cmd.start_run) begin
      status_r <= verdict;
      idx_r    <= '0;
    end else if (cmd.advance) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  // Payload memory
  assign rd_addr = cmd.advance ? idx_r + 1'b1 : idx_r;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_off[IDX_W-1:0]] <= byte_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result fields
  assign has_crc           = (status_r == ST_OK) || (status_r == ST_CRC);
  assign out_status        = status_r;
  assign out_slave_address = addr_r;
  assign out_function_code = func_r;
  assign out_byte_count    = (status_r == ST_FUNC) ? 8'd0 : len_r;
  assign out_data_index    = idx_r;
  assign out_data_byte     = (has_crc && len_r != 8'd0) ? rd_data_r : 8'd0;
  assign out_crc_computed  = has_crc ? frozen_r : 16'd0;
  assign out_crc_received  = has_crc ? frame_crc_r : 16'd0;
  assign sts.run_last      = !has_crc || (len_r == 8'd0) ||
                             ({3'b000, idx_r} + 8'd1 == len_r);
  assign out_last          = sts.run_last;

endmodule

### rtl/modbus_rtu_frame_receiver.sv
// Modbus RTU receiver top: a byte that reports no frame passes the check and take states before ready.
// A closing byte that reports a frame gives its first result after the check and read states,
// then one result per cycle while the output is taken.
// Each result needs one registered read of the 32-entry payload memory, pipelined one ahead.
// Reset (rst_n, synchronous, active low): frame empty, gap setting 4 ms, CRC preset 0xFFFF.
module modbus_rtu_frame_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_gap_ms,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_slave_address,
  output logic [7:0]  out_function_code,
  output logic [7:0]  out_byte_count,
  output logic [4:0]  out_data_index,
  output logic [7:0]  out_data_byte,
  output logic [15:0] out_crc_computed,
  output logic [15:0] out_crc_received,
  output logic        out_last
);
  import mbrx_pkg::*;

  mbrx_cmd_t cmd;
  mbrx_sts_t sts;

  // Configuration is always taken
  assign cfg_ready = 1'b1;

  // Sequencer
  mbrx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Frame datapath
  mbrx_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_gap_ms        (cfg_gap_ms),
    .in_rx_byte        (in_rx_byte),
    .in_time_ms        (in_time_ms),
    .cmd               (cmd),
    .sts               (sts),
    .out_status        (out_status),
    .out_slave_address (out_slave_address),
    .out_function_code (out_function_code),
    .out_byte_count    (out_byte_count),
    .out_data_index    (out_data_index),
    .out_data_byte     (out_data_byte),
    .out_crc_computed  (out_crc_computed),
    .out_crc_received  (out_crc_received),
    .out_last          (out_last)
  );

endmodule
